/* hw/rtl/jddm_pkg.sv */
// Shared types, constants and codes for the joystick differential-drive mixer.
package jddm_pkg;

  // Shared multiplier operand and product widths
  localparam int MUL_W  = 28;
  localparam int PROD_W = 2 * MUL_W;

  // floor(x / 1000) = ((x >> 3) * DIV_M) >> DIV_SH, exact for x < 2^30
  localparam logic [MUL_W-1:0] DIV_M  = 28'd137438954;
  localparam int               DIV_SH = 34;

  // Handbrake request codes
  localparam logic [1:0] WISH_NONE    = 2'd0;
  localparam logic [1:0] WISH_BRAKE   = 2'd1;
  localparam logic [1:0] WISH_RELEASE = 2'd2;

  // Hold modes
  localparam logic [1:0] HOLD_OPEN   = 2'd1;
  localparam logic [1:0] HOLD_SPEED0 = 2'd2;

  // Command kinds
  localparam logic [2:0] KIND_DRIVE     = 3'd0;
  localparam logic [2:0] KIND_IDLE_OPEN = 3'd1;
  localparam logic [2:0] KIND_HOLD_OFF  = 3'd2;
  localparam logic [2:0] KIND_HOLD_OPEN = 3'd3;
  localparam logic [2:0] KIND_HOLD_SPD0 = 3'd4;
  localparam logic [2:0] KIND_RELEASING = 3'd5;

  // Configuration register indexes
  localparam logic [2:0] REG_FLAGS    = 3'd0;
  localparam logic [2:0] REG_TGAIN    = 3'd1;
  localparam logic [2:0] REG_BGAIN    = 3'd2;
  localparam logic [2:0] REG_SMOOTH   = 3'd3;
  localparam logic [2:0] REG_SG_STAND = 3'd4;
  localparam logic [2:0] REG_SG_FAST  = 3'd5;
  localparam logic [2:0] REG_AB_DELAY = 3'd6;
  localparam logic [2:0] REG_HOLD     = 3'd7;

  // Sequencer steps
  typedef enum logic [3:0] {
    ST_IDLE, ST_GM, ST_BM, ST_P1, ST_Q1, ST_P2, ST_Q2, ST_LIM,
    ST_STD, ST_STG, ST_STQ, ST_DEC, ST_LQ, ST_RQ, ST_FIN
  } state_t;

endpackage

/* hw/rtl/jddm_if.sv */
// Tick and result channel interfaces for the mixer.
interface jddm_tick_if;
  logic               valid;
  logic               ready;
  logic               joystick_valid;
  logic signed [10:0] steer_axis;
  logic signed [10:0] drive_axis;
  logic signed [10:0] speed_tenths;
  logic [15:0]        elapsed_ms;
  logic               feedback_ok;
  logic [1:0]         wish_request;
  logic               update_done;
  modport source (output valid, joystick_valid, steer_axis, drive_axis, speed_tenths,
                  elapsed_ms, feedback_ok, wish_request, update_done, input ready);
  modport sink (input valid, joystick_valid, steer_axis, drive_axis, speed_tenths,
                elapsed_ms, feedback_ok, wish_request, update_done, output ready);
endinterface

interface jddm_result_if;
  logic               valid;
  logic               ready;
  logic signed [11:0] left_pwm;
  logic signed [11:0] right_pwm;
  logic [2:0]         command_kind;
  logic               brake_engaged;
  logic [1:0]         pending_wish;
  modport source (output valid, left_pwm, right_pwm, command_kind, brake_engaged,
                  pending_wish, input ready);
  modport sink (input valid, left_pwm, right_pwm, command_kind, brake_engaged,
                pending_wish, output ready);
endinterface

/* hw/rtl/jddm_mul.sv */
// Shared unsigned multiplier with registered product.
module jddm_mul (
  input  logic                          clk,
  input  logic [jddm_pkg::MUL_W-1:0]    a,
  input  logic [jddm_pkg::MUL_W-1:0]    b,
  output logic [jddm_pkg::PROD_W-1:0]   p
);

  // product register
  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

/* hw/rtl/joystick_differential_drive_mixer.sv */
// A transferred tick runs the steps GM through FIN in order; with joystick invalid it skips to LQ.
// One tick at a time, taken only in the idle step; one shared multiplier runs
//   most products and every divide by 1000 in turn, one per cycle, under the step sequencer.
// A finished result waits in the output register; the next tick is taken meanwhile.
// Reset (rst, synchronous): configuration to defaults, handbrake and smoothing
//   state cleared, both release waits armed, no result pending.
module joystick_differential_drive_mixer (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [2:0]           cfg_index,
  input  logic [9:0]           cfg_data,
  jddm_tick_if.sink            tick,
  jddm_result_if.source        result
);

  localparam int MW = jddm_pkg::MUL_W;
  localparam int PW = jddm_pkg::PROD_W;

  // configuration
  logic [7:0] flags;
  logic [9:0] tgain, bgain, smooth, sg_stand, sg_fast;
  logic [7:0] ab_delay;
  logic [1:0] hold;

  always_ff @(posedge clk) begin
    if (rst) begin
      flags <= '0; tgain <= 10'd1000; bgain <= 10'd1000; smooth <= 10'd20;
      sg_stand <= 10'd1000; sg_fast <= 10'd500; ab_delay <= 8'd10; hold <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        jddm_pkg::REG_FLAGS:    flags <= cfg_data[7:0];
        jddm_pkg::REG_TGAIN:    tgain <= cfg_data;
        jddm_pkg::REG_BGAIN:    bgain <= cfg_data;
        jddm_pkg::REG_SMOOTH:   smooth <= cfg_data;
        jddm_pkg::REG_SG_STAND: sg_stand <= cfg_data;
        jddm_pkg::REG_SG_FAST:  sg_fast <= cfg_data;
        jddm_pkg::REG_AB_DELAY: ab_delay <= cfg_data[7:0];
        jddm_pkg::REG_HOLD:     hold <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  jddm_pkg::state_t state, state_next;
  logic accept;
  logic load_out;
  logic [MW-1:0] ma, mb;
  logic [PW-1:0] p;

  jddm_mul u_mul (.clk(clk), .a(ma), .b(mb), .p(p));

  // persistent state
  logic wait_t, wait_b, engaged, wish_timer_on, standstill_on, released_once;
  logic releasing, motor_done;
  logic [1:0] wish;
  logic [15:0] wish_age, standstill_ms, since_release, release_ms, since_drive;
  logic signed [21:0] prev_pwm;

  // per-tick working registers
  logic fb_ok;
  logic signed [10:0] lr;
  logic [10:0] aspeed, g, b;
  logic [20:0] gm, bm, q1, q2;
  logic [29:0] lim;
  logic signed [22:0] left_m, right_m;
  logic [2:0] kind_r;
  logic signed [11:0] left_q;

  // input decode
  logic signed [11:0] fbk;
  logic [10:0] g_in, b_in, aspeed_in;
  logic signed [11:0] spd_ext;
  logic new_wish;

  always_comb begin
    fbk = flags[7] ? 12'sd0 : -{tick.drive_axis[10], tick.drive_axis};
    g_in = (fbk > 12'sd0) ? fbk[10:0] : 11'd0;
    b_in = (fbk < 12'sd0) ? 11'((-fbk)) : 11'd0;
    spd_ext = {tick.speed_tenths[10], tick.speed_tenths};
    aspeed_in = (spd_ext < 12'sd0) ? 11'((-spd_ext)) : spd_ext[10:0];
    new_wish = (tick.wish_request == jddm_pkg::WISH_BRAKE) ||
               (tick.wish_request == jddm_pkg::WISH_RELEASE);
  end

  function automatic logic [15:0] age_add(input logic [15:0] a, input logic [15:0] d);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, d};
    return s[16] ? 16'hFFFF : s[15:0];
  endfunction

  assign accept = tick.valid && tick.ready;

  // next step
  always_comb begin
    state_next = state;
    case (state)
      jddm_pkg::ST_IDLE: if (accept) state_next = tick.joystick_valid ? jddm_pkg::ST_GM
                                                                      : jddm_pkg::ST_LQ;
      jddm_pkg::ST_GM:  state_next = jddm_pkg::ST_BM;
      jddm_pkg::ST_BM:  state_next = jddm_pkg::ST_P1;
      jddm_pkg::ST_P1:  state_next = jddm_pkg::ST_Q1;
      jddm_pkg::ST_Q1:  state_next = jddm_pkg::ST_P2;
      jddm_pkg::ST_P2:  state_next = jddm_pkg::ST_Q2;
      jddm_pkg::ST_Q2:  state_next = jddm_pkg::ST_LIM;
      jddm_pkg::ST_LIM: state_next = jddm_pkg::ST_STD;
      jddm_pkg::ST_STD: state_next = jddm_pkg::ST_STG;
      jddm_pkg::ST_STG: state_next = jddm_pkg::ST_STQ;
      jddm_pkg::ST_STQ: state_next = jddm_pkg::ST_DEC;
      jddm_pkg::ST_DEC: state_next = jddm_pkg::ST_LQ;
      jddm_pkg::ST_LQ:  state_next = jddm_pkg::ST_RQ;
      jddm_pkg::ST_RQ:  state_next = jddm_pkg::ST_FIN;
      jddm_pkg::ST_FIN: if (load_out) state_next = jddm_pkg::ST_IDLE;
      default: state_next = jddm_pkg::ST_IDLE;
    endcase
  end

  // steering gain from standstill to fast, interpolated over speed
  logic [9:0] sg_diff;
  logic [10:0] lr_mag;
  logic signed [21:0] gain_s;
  logic [8:0] t_lim;
  logic [22:0] left_mag, right_mag;

  always_comb begin
    sg_diff = (sg_fast >= sg_stand) ? sg_fast - sg_stand : sg_stand - sg_fast;
    lr_mag = lr[10] ? 11'((-{lr[10], lr})) : lr[10:0];
    t_lim = (aspeed > 11'd500) ? 9'd500 : aspeed[8:0];
    gain_s = (sg_fast >= sg_stand)
           ? 22'(sg_stand * 20'd1000) + $signed({1'b0, p[20:0]})
           : 22'(sg_stand * 20'd1000) - $signed({1'b0, p[20:0]});
    left_mag = left_m[22] ? 23'((-left_m)) : left_m;
    right_mag = right_m[22] ? 23'((-right_m)) : right_m;
  end

  // multiplier operands and handshakes
  always_comb begin
    ma = '0;
    mb = '0;
    case (state)
      jddm_pkg::ST_GM: begin
        ma = MW'(g); mb = flags[0] ? MW'(g) : MW'(10'd1000);
      end
      jddm_pkg::ST_BM: begin
        ma = MW'(b); mb = flags[1] ? MW'(b) : MW'(10'd1000);
      end
      jddm_pkg::ST_P1: begin
        ma = MW'(gm); mb = MW'(tgain);
      end
      jddm_pkg::ST_Q1, jddm_pkg::ST_Q2, jddm_pkg::ST_STQ: begin
        ma = MW'(p[29:3]); mb = jddm_pkg::DIV_M;
      end
      jddm_pkg::ST_P2: begin
        ma = MW'(bm); mb = MW'(bgain);
      end
      jddm_pkg::ST_LIM: begin
        ma = MW'(since_drive); mb = MW'({smooth, 3'b000}) + MW'({smooth, 1'b0});
      end
      jddm_pkg::ST_STD: begin
        ma = MW'(sg_diff); mb = MW'({t_lim, 1'b0});
      end
      jddm_pkg::ST_STG: begin
        ma = MW'(gain_s[20:0]); mb = MW'(lr_mag);
      end
      jddm_pkg::ST_LQ: begin
        ma = MW'(left_mag[22:3]); mb = jddm_pkg::DIV_M;
      end
      jddm_pkg::ST_RQ, jddm_pkg::ST_FIN: begin
        ma = MW'(right_mag[22:3]); mb = jddm_pkg::DIV_M;
      end
      default: ;
    endcase
  end

  assign tick.ready = (state == jddm_pkg::ST_IDLE);
  assign load_out = (state == jddm_pkg::ST_FIN) && (!result.valid || result.ready);

  // decision: handbrake machine and drive path
  logic d_eng, d_tmr, d_ss, d_ro, d_rel, d_md, d_drive;
  logic [1:0] d_wish;
  logic [15:0] d_ssms, d_srm, d_rms;
  logic [2:0] d_kind;
  logic signed [21:0] d_pwm;
  logic signed [22:0] d_left, d_right;
  logic signed [21:0] pwm_raw;
  logic signed [32:0] lim_hi, lim_lo;
  logic signed [21:0] steer_m;
  logic [15:0] ab_ms;
  logic big_pedal;

  always_comb begin
    d_eng = engaged; d_tmr = wish_timer_on; d_ss = standstill_on; d_ro = released_once;
    d_rel = releasing; d_md = motor_done; d_wish = wish; d_ssms = standstill_ms;
    d_srm = since_release; d_rms = release_ms; d_kind = jddm_pkg::KIND_DRIVE;
    d_pwm = prev_pwm; d_left = '0; d_right = '0; d_drive = 1'b0;
    pwm_raw = $signed({1'b0, q1}) - $signed({1'b0, q2});
    lim_hi = 33'(prev_pwm) + $signed({3'b000, lim});
    lim_lo = 33'(prev_pwm) - $signed({3'b000, lim});
    steer_m = lr[10] ? -$signed({1'b0, p[jddm_pkg::DIV_SH +: 21]})
                     : $signed({1'b0, p[jddm_pkg::DIV_SH +: 21]});
    ab_ms = 16'(ab_delay * 16'd100);
    big_pedal = (gm > 21'd10000) || (bm > 21'd10000);

    // manual brake request
    if (flags[4] && d_wish == jddm_pkg::WISH_BRAKE && aspeed < 11'd20 &&
        gm < 21'd1000 && bm < 21'd1000) begin
      d_eng = 1'b1;
      d_wish = jddm_pkg::WISH_NONE;
    end
    // automatic brake at standstill
    if (flags[4] && flags[5] && !d_eng) begin
      if (aspeed < 11'd10) begin
        if (!d_ss) begin
          d_ss = 1'b1;
          d_ssms = '0;
        end
      end else begin
        d_ss = 1'b0;
      end
      if (d_ss && d_ro && d_ssms > ab_ms && d_srm > 16'd5000) d_eng = 1'b1;
    end
    // request expiry
    if (d_tmr && wish_age > 16'd5000) begin
      d_wish = jddm_pkg::WISH_NONE;
      d_tmr = 1'b0;
    end

    if (d_eng) begin
      d_ss = 1'b0;
      if (d_wish == jddm_pkg::WISH_RELEASE) begin
        d_ro = 1'b1; d_srm = '0; d_rel = 1'b1; d_rms = '0; d_md = 1'b0;
        d_wish = jddm_pkg::WISH_NONE;
      end
      if (fb_ok && big_pedal && !d_rel) begin
        d_ro = 1'b1; d_srm = '0; d_rel = 1'b1; d_rms = '0; d_md = 1'b0;
      end
      if (d_rel) begin
        d_kind = jddm_pkg::KIND_RELEASING;
        if (d_rms > 16'd1000 || d_md) begin
          d_rel = 1'b0;
          d_eng = 1'b0;
        end
      end else if (hold == jddm_pkg::HOLD_OPEN) begin
        d_kind = jddm_pkg::KIND_HOLD_OPEN;
      end else if (hold == jddm_pkg::HOLD_SPEED0) begin
        d_kind = jddm_pkg::KIND_HOLD_SPD0;
      end else begin
        d_kind = jddm_pkg::KIND_HOLD_OFF;
      end
    end else begin
      // rate limit toward the new command
      d_drive = 1'b1;
      d_pwm = pwm_raw;
      if (prev_pwm < pwm_raw && flags[2]) begin
        if (33'(pwm_raw) > lim_hi) d_pwm = 22'(lim_hi);
      end else if (prev_pwm > pwm_raw && flags[3]) begin
        if (33'(pwm_raw) < lim_lo) d_pwm = 22'(lim_lo);
      end
      d_left = 23'(d_pwm) - 23'(steer_m);
      d_right = 23'(d_pwm) + 23'(steer_m);
    end
  end

  // divided magnitude back to a saturated signed PWM
  function automatic logic signed [11:0] pwm_sat(input logic [11:0] q, input logic neg);
    logic [11:0] m;
    m = (q > 12'd2000) ? 12'd2000 : q;
    return neg ? -$signed(m) : $signed(m);
  endfunction

  // state and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= jddm_pkg::ST_IDLE;
      wait_t <= 1'b1; wait_b <= 1'b1; engaged <= 1'b0; wish <= jddm_pkg::WISH_NONE;
      wish_timer_on <= 1'b0; wish_age <= '0; standstill_on <= 1'b0; standstill_ms <= '0;
      released_once <= 1'b0; since_release <= '0; releasing <= 1'b0; release_ms <= '0;
      motor_done <= 1'b0; prev_pwm <= '0; since_drive <= '0;
      result.valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_out) result.valid <= 1'b1;
      else if (result.ready) result.valid <= 1'b0;
      case (state)
        jddm_pkg::ST_IDLE: if (accept) begin
          wish_age <= new_wish ? 16'd0 : age_add(wish_age, tick.elapsed_ms);
          standstill_ms <= age_add(standstill_ms, tick.elapsed_ms);
          since_release <= age_add(since_release, tick.elapsed_ms);
          release_ms <= age_add(release_ms, tick.elapsed_ms);
          since_drive <= age_add(since_drive, tick.elapsed_ms);
          if (new_wish) begin
            wish <= tick.wish_request;
            wish_timer_on <= 1'b1;
          end
          if (tick.update_done) motor_done <= 1'b1;
          fb_ok <= tick.feedback_ok;
          lr <= flags[6] ? 11'sd0 : tick.steer_axis;
          aspeed <= aspeed_in;
          kind_r <= jddm_pkg::KIND_IDLE_OPEN;
          left_m <= '0;
          right_m <= '0;
          // each pedal counts only after it has been released below 50
          g <= (tick.joystick_valid && wait_t && g_in >= 11'd50) ? 11'd0 : g_in;
          b <= (tick.joystick_valid && wait_b && b_in >= 11'd50) ? 11'd0 : b_in;
          if (tick.joystick_valid) begin
            if (wait_t && g_in < 11'd50) wait_t <= 1'b0;
            if (wait_b && b_in < 11'd50) wait_b <= 1'b0;
          end
        end
        jddm_pkg::ST_BM:  gm <= p[20:0];
        jddm_pkg::ST_P1:  bm <= p[20:0];
        jddm_pkg::ST_P2:  q1 <= p[jddm_pkg::DIV_SH +: 21];
        jddm_pkg::ST_LIM: q2 <= p[jddm_pkg::DIV_SH +: 21];
        jddm_pkg::ST_STD: lim <= p[29:0];
        jddm_pkg::ST_DEC: begin
          engaged <= d_eng; wish <= d_wish; wish_timer_on <= d_tmr;
          standstill_on <= d_ss; standstill_ms <= d_ssms; released_once <= d_ro;
          since_release <= d_srm; releasing <= d_rel; release_ms <= d_rms;
          motor_done <= d_md; prev_pwm <= d_pwm;
          if (d_drive) since_drive <= '0;
          left_m <= d_left; right_m <= d_right; kind_r <= d_kind;
        end
        jddm_pkg::ST_RQ: left_q <= pwm_sat(p[jddm_pkg::DIV_SH +: 12], left_m[22]);
        jddm_pkg::ST_FIN: if (load_out) begin
          result.left_pwm <= left_q;
          result.right_pwm <= pwm_sat(p[jddm_pkg::DIV_SH +: 12], right_m[22]);
          result.command_kind <= kind_r;
          result.brake_engaged <= engaged;
          result.pending_wish <= wish;
        end
        default: ;
      endcase
    end
  end

  // a tick only starts work from the idle step
  assert property (@(posedge clk) disable iff (rst)
    accept |=> state != jddm_pkg::ST_IDLE)
    else $error("tick transfer did not start the sequencer");

  // drive commands never coexist with an engaged handbrake
  assert property (@(posedge clk) disable iff (rst)
    result.valid && result.command_kind == jddm_pkg::KIND_DRIVE |-> !result.brake_engaged)
    else $error("drive command with handbrake engaged");

  // engaged handbrake means zero wheel commands
  assert property (@(posedge clk) disable iff (rst)
    result.valid && result.brake_engaged |-> result.left_pwm == 12'sd0 &&
      result.right_pwm == 12'sd0)
    else $error("nonzero PWM while handbrake engaged");

  // saturation bounds on both wheels
  assert property (@(posedge clk) disable iff (rst)
    result.valid |-> result.left_pwm <= 12'sd2000 && result.left_pwm >= -12'sd2000 &&
      result.right_pwm <= 12'sd2000 && result.right_pwm >= -12'sd2000)
    else $error("PWM outside saturation range");

  // joystick loss gives the idle-open command
  assert property (@(posedge clk) disable iff (rst)
    accept && !tick.joystick_valid |=> kind_r == jddm_pkg::KIND_IDLE_OPEN)
    else $error("invalid joystick not mapped to idle open");

endmodule
